@@ sv/cartridge_bank_mapper_with_irq_macros.svh @@
// Assertion helpers for the bank mapper.
`ifndef CARTRIDGE_BANK_MAPPER_WITH_IRQ_MACROS_SVH
`define CARTRIDGE_BANK_MAPPER_WITH_IRQ_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define CBM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bank mapper check failed");

// Next-cycle implication, held off while reset is asserted.
`define CBM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bank mapper check failed");

`endif

@@ sv/cbm_pkg.sv @@
package cbm_pkg;

    // Command codes of an input beat
    typedef enum logic [1:0]
    {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_PPU   = 2'd2,
        CMD_TICK  = 2'd3
    } cmd_code_t;

    // CPU register decode on address bits 15:11
    localparam logic [4:0] SEL_IRQ_LO    = 5'h0A;
    localparam logic [4:0] SEL_IRQ_HI    = 5'h0B;
    localparam logic [4:0] SEL_CHR_FIRST = 5'h10;
    localparam logic [4:0] SEL_CHR_LAST  = 5'h17;
    localparam logic [4:0] SEL_NT_FIRST  = 5'h18;
    localparam logic [4:0] SEL_NT_LAST   = 5'h1B;
    localparam logic [4:0] SEL_PRG_FIRST = 5'h1C;
    localparam logic [4:0] SEL_PRG_LAST  = 5'h1E;

    // Configuration register indexes
    localparam logic CFG_PRG_COUNT = 1'b0;
    localparam logic CFG_CHR_COUNT = 1'b1;

    localparam int CFG_DATA_W = 9;

    localparam logic [15:0] IRQ_STEP    = 16'd114;
    localparam logic [15:0] IRQ_LIMIT   = 16'h7FFF;
    localparam logic [15:0] IRQ_FLAG    = 16'h8000;
    localparam logic [7:0]  NT_CIRAM    = 8'hE0;
    localparam logic [7:0]  READ_IDLE   = 8'hFF;
    localparam logic [1:0]  PRG_FIXED   = 2'd3;

    typedef struct packed
    {
        logic latch;
        logic exec;
        logic div_step;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed
    {
        logic need_div;
        logic div_last;
    } dp_status_t;

endpackage

@@ sv/cbm_if.sv @@
interface cbm_item_if;
    import cbm_pkg::*;

    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [15:0] address;
    logic [7:0]  data;

    modport source (output valid, output cmd, output address, output data, input ready);
    modport sink   (input valid, input cmd, input address, input data, output ready);
endinterface

interface cbm_result_if;
    import cbm_pkg::*;

    logic        valid;
    logic        ready;
    logic [7:0]  read_data;
    logic        prg_hit;
    logic [18:0] prg_rom_address;
    logic        chr_hit;
    logic [17:0] chr_rom_address;
    logic        ciram_hit;
    logic [10:0] ciram_address;
    logic        irq_pulse;

    modport source
    (
        output valid, output read_data, output prg_hit, output prg_rom_address,
        output chr_hit, output chr_rom_address, output ciram_hit,
        output ciram_address, output irq_pulse, input ready
    );
    modport sink
    (
        input valid, input read_data, input prg_hit, input prg_rom_address,
        input chr_hit, input chr_rom_address, input ciram_hit,
        input ciram_address, input irq_pulse, output ready
    );
endinterface

interface cbm_cfg_if;
    import cbm_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ sv/cartridge_bank_mapper_with_irq.sv @@
// Channel   Direction  Payload                                         Beat taken when
// item      in         cmd, address, data                              item.valid & item.ready
// result    out        read_data, prg_hit, prg_rom_address, chr_hit,   result.valid & result.ready
//                      chr_rom_address, ciram_hit, ciram_address,
//                      irq_pulse
// cfg       in         index (0 prg_bank_count, 1 chr_page_count),     cfg.valid & cfg.ready
//                      data
//
// An item passes accept, execute and write-back; a nametable fetch whose select is below
// 0xE0 with a non-zero page count also iterates the two-bit-per-cycle remainder unit
// between execute and write-back. The next item is taken in the cycle after write-back.
// Reset restores all mapper registers at once; no clearing pass is needed.
// A finished result waits in the output register while the next item is taken; write-back
// stalls only while that register is still full and not being drained.
// cfg.ready is held high, so a configuration beat is never stalled.
module cartridge_bank_mapper_with_irq
(
    input  logic          clk,
    input  logic          rst_n,
    cbm_item_if.sink      item,
    cbm_result_if.source  result,
    cbm_cfg_if.sink       cfg
);
    import cbm_pkg::*;

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    // No back-pressure: the user must write configuration only while idle; not enforced.
    assign cfg.ready = 1'b1;

    // Sequence each item: latch, execute, iterate the remainder if needed, write back.
    cbm_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item.valid),
        .item_ready   (item.ready),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .status       (dp_status),
        .cmd          (dp_cmd)
    );

    // Hold the mapper registers, decode the beat and build the result.
    cbm_datapath u_datapath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (dp_cmd),
        .status          (dp_status),
        .item_cmd        (item.cmd),
        .item_address    (item.address),
        .item_data       (item.data),
        .cfg_valid       (cfg.valid),
        .cfg_index       (cfg.index),
        .cfg_data        (cfg.data),
        .read_data       (result.read_data),
        .prg_hit         (result.prg_hit),
        .prg_rom_address (result.prg_rom_address),
        .chr_hit         (result.chr_hit),
        .chr_rom_address (result.chr_rom_address),
        .ciram_hit       (result.ciram_hit),
        .ciram_address   (result.ciram_address),
        .irq_pulse       (result.irq_pulse)
    );

`include "cartridge_bank_mapper_with_irq_macros.svh"

    // Once a beat is taken, take no further beat until that item is written back.
    `CBM_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, item.valid && item.ready, !item.ready)
    // Never overwrite a result that the sink has not yet taken.
    `CBM_ASSERT_NOW(a_no_overwrite, clk, rst_n, dp_cmd.load_out, !result.valid || result.ready)
    // Write-back always presents a result on the following cycle.
    `CBM_ASSERT_NEXT(a_load_shows, clk, rst_n, dp_cmd.load_out, result.valid)

endmodule

@@ sv/cbm_ctrl.sv @@
module cbm_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    output logic                result_valid,
    input  logic                result_ready,
    input  cbm_pkg::dp_status_t status,
    output cbm_pkg::dp_cmd_t    cmd
);
    import cbm_pkg::*;

    typedef enum logic [3:0]
    {
        ST_IDLE = 4'b0001,
        ST_EXEC = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_WB   = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = status.need_div ? ST_DIV : ST_WB;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_WB;
                end
            end
            ST_WB:
            begin
                // wait for the output register to drain
                if (!out_valid_reg || result_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign item_ready   = (state_reg == ST_IDLE);
    assign result_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ sv/cbm_datapath.sv @@
module cbm_datapath
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  cbm_pkg::dp_cmd_t                cmd,
    output cbm_pkg::dp_status_t             status,
    input  logic [1:0]                      item_cmd,
    input  logic [15:0]                     item_address,
    input  logic [7:0]                      item_data,
    input  logic                            cfg_valid,
    input  logic                            cfg_index,
    input  logic [cbm_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic [7:0]                      read_data,
    output logic                            prg_hit,
    output logic [18:0]                     prg_rom_address,
    output logic                            chr_hit,
    output logic [17:0]                     chr_rom_address,
    output logic                            ciram_hit,
    output logic [10:0]                     ciram_address,
    output logic                            irq_pulse
);
    import cbm_pkg::*;

    // item held for execution
    logic [1:0]  it_cmd_reg;
    logic [15:0] it_addr_reg;
    logic [7:0]  it_data_reg;

    // mapper state
    logic [15:0] irq_count_reg,  irq_count_next;
    logic        irq_enable_reg, irq_enable_next;
    logic [7:0]  pattern_bank_reg [8];
    logic [7:0]  pattern_bank_next [8];
    logic [7:0]  nt_sel_reg [4];
    logic [7:0]  nt_sel_next [4];
    logic [5:0]  prg_bank_reg [3];
    logic [5:0]  prg_bank_next [3];
    logic [6:0]  prg_count_reg, prg_count_next;
    logic [8:0]  chr_count_reg, chr_count_next;

    // remainder unit
    logic [7:0]  div_rem_reg, div_rem_next;
    logic [7:0]  div_num_reg, div_num_next;
    logic [1:0]  div_cnt_reg, div_cnt_next;

    // result of the item in flight
    logic [7:0]  res_read_reg,  res_read_next;
    logic        res_prg_hit_reg, res_prg_hit_next;
    logic [18:0] res_prg_addr_reg, res_prg_addr_next;
    logic        res_chr_hit_reg, res_chr_hit_next;
    logic [17:0] res_chr_addr_reg, res_chr_addr_next;
    logic        res_ciram_hit_reg, res_ciram_hit_next;
    logic [10:0] res_ciram_addr_reg, res_ciram_addr_next;
    logic        res_irq_reg, res_irq_next;

    // output register
    logic [7:0]  out_read_reg;
    logic        out_prg_hit_reg;
    logic [18:0] out_prg_addr_reg;
    logic        out_chr_hit_reg;
    logic [17:0] out_chr_addr_reg;
    logic        out_ciram_hit_reg;
    logic [10:0] out_ciram_addr_reg;
    logic        out_irq_reg;

    logic [4:0]  sel;
    logic [13:0] ppu_addr;
    logic [9:0]  offset;
    logic [7:0]  nt_value;
    logic [7:0]  pat_value;
    logic [1:0]  slot;
    logic [5:0]  prg_bank;
    logic [15:0] tick_sum;
    logic [8:0]  div_t1, div_t2;
    logic [7:0]  div_r1, div_r2;

    assign sel       = it_addr_reg[15:11];
    assign ppu_addr  = it_addr_reg[13:0];
    assign offset    = ppu_addr[9:0];
    assign nt_value  = nt_sel_reg[ppu_addr[11:10]];
    assign pat_value = pattern_bank_reg[ppu_addr[12:10]];
    assign slot      = it_addr_reg[14:13];
    assign prg_bank  = (slot == PRG_FIXED) ? (prg_count_reg[5:0] - 6'd1) : prg_bank_reg[slot];
    assign tick_sum  = irq_count_reg + IRQ_STEP;

    // two restoring remainder steps per cycle
    assign div_t1 = {div_rem_reg, div_num_reg[7]};
    assign div_r1 = (div_t1 >= chr_count_reg) ? 8'(div_t1 - chr_count_reg) : div_t1[7:0];
    assign div_t2 = {div_r1, div_num_reg[6]};
    assign div_r2 = (div_t2 >= chr_count_reg) ? 8'(div_t2 - chr_count_reg) : div_t2[7:0];

    assign status.need_div = (it_cmd_reg == CMD_PPU) && ppu_addr[13]
                             && (nt_value < NT_CIRAM) && (chr_count_reg != 9'd0);
    assign status.div_last = (div_cnt_reg == 2'd3);

    always_comb
    begin
        irq_count_next      = irq_count_reg;
        irq_enable_next     = irq_enable_reg;
        pattern_bank_next   = pattern_bank_reg;
        nt_sel_next         = nt_sel_reg;
        prg_bank_next       = prg_bank_reg;
        prg_count_next      = prg_count_reg;
        chr_count_next      = chr_count_reg;
        div_rem_next        = div_rem_reg;
        div_num_next        = div_num_reg;
        div_cnt_next        = div_cnt_reg;
        res_read_next       = res_read_reg;
        res_prg_hit_next    = res_prg_hit_reg;
        res_prg_addr_next   = res_prg_addr_reg;
        res_chr_hit_next    = res_chr_hit_reg;
        res_chr_addr_next   = res_chr_addr_reg;
        res_ciram_hit_next  = res_ciram_hit_reg;
        res_ciram_addr_next = res_ciram_addr_reg;
        res_irq_next        = res_irq_reg;

        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_PRG_COUNT: prg_count_next = cfg_data[6:0];
                CFG_CHR_COUNT: chr_count_next = cfg_data;
                default: ;
            endcase
        end

        if (cmd.exec)
        begin
            res_read_next       = READ_IDLE;
            res_prg_hit_next    = 1'b0;
            res_prg_addr_next   = '0;
            res_chr_hit_next    = 1'b0;
            res_chr_addr_next   = '0;
            res_ciram_hit_next  = 1'b0;
            res_ciram_addr_next = '0;
            res_irq_next        = 1'b0;

            unique case (it_cmd_reg)
                CMD_WRITE:
                begin
                    unique case (sel) inside
                        SEL_IRQ_LO:
                        begin
                            irq_count_next = {1'b0, irq_count_reg[14:8], it_data_reg};
                        end
                        SEL_IRQ_HI:
                        begin
                            irq_count_next  = {1'b0, it_data_reg[6:0], irq_count_reg[7:0]};
                            irq_enable_next = it_data_reg[7];
                        end
                        [SEL_CHR_FIRST:SEL_CHR_LAST]:
                        begin
                            pattern_bank_next[sel[2:0]] = it_data_reg;
                        end
                        [SEL_NT_FIRST:SEL_NT_LAST]:
                        begin
                            nt_sel_next[sel[1:0]] = it_data_reg;
                        end
                        [SEL_PRG_FIRST:SEL_PRG_LAST]:
                        begin
                            prg_bank_next[sel[1:0]] = it_data_reg[5:0];
                        end
                        default: ;
                    endcase
                end
                CMD_READ:
                begin
                    if (sel == SEL_IRQ_LO)
                    begin
                        res_read_next = irq_count_reg[7:0];
                    end
                    else if (sel == SEL_IRQ_HI)
                    begin
                        // top bit shows the enable or the raised flag
                        res_read_next = {irq_enable_reg | irq_count_reg[15], irq_count_reg[14:8]};
                    end
                    else if (it_addr_reg[15])
                    begin
                        res_prg_hit_next  = 1'b1;
                        res_prg_addr_next = {prg_bank, it_addr_reg[12:0]};
                    end
                end
                CMD_PPU:
                begin
                    if (!ppu_addr[13])
                    begin
                        res_chr_hit_next  = 1'b1;
                        res_chr_addr_next = {pat_value, offset};
                    end
                    else if (nt_value < NT_CIRAM)
                    begin
                        // page refined by the remainder unit when a count is set
                        res_chr_hit_next  = 1'b1;
                        res_chr_addr_next = {nt_value, offset};
                        div_rem_next      = '0;
                        div_num_next      = nt_value;
                        div_cnt_next      = '0;
                    end
                    else
                    begin
                        res_ciram_hit_next  = 1'b1;
                        res_ciram_addr_next = {nt_value[0], offset};
                    end
                end
                CMD_TICK:
                begin
                    if (irq_enable_reg)
                    begin
                        if (tick_sum >= IRQ_LIMIT)
                        begin
                            irq_count_next = tick_sum | IRQ_FLAG;
                            res_irq_next   = 1'b1;
                        end
                        else
                        begin
                            irq_count_next = tick_sum;
                        end
                    end
                end
                default: ;
            endcase
        end

        if (cmd.div_step)
        begin
            div_rem_next      = div_r2;
            div_num_next      = {div_num_reg[5:0], 2'b00};
            div_cnt_next      = div_cnt_reg + 2'd1;
            res_chr_addr_next = {div_r2, res_chr_addr_reg[9:0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            irq_count_reg  <= '0;
            irq_enable_reg <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                pattern_bank_reg[i] <= 8'(i);
            end
            for (int i = 0; i < 4; i++)
            begin
                nt_sel_reg[i] <= NT_CIRAM;
            end
            for (int i = 0; i < 3; i++)
            begin
                prg_bank_reg[i] <= 6'(i);
            end
            prg_count_reg <= 7'd64;
            chr_count_reg <= 9'd256;
        end
        else
        begin
            irq_count_reg    <= irq_count_next;
            irq_enable_reg   <= irq_enable_next;
            pattern_bank_reg <= pattern_bank_next;
            nt_sel_reg       <= nt_sel_next;
            prg_bank_reg     <= prg_bank_next;
            prg_count_reg    <= prg_count_next;
            chr_count_reg    <= chr_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            it_cmd_reg  <= item_cmd;
            it_addr_reg <= item_address;
            it_data_reg <= item_data;
        end
        div_rem_reg        <= div_rem_next;
        div_num_reg        <= div_num_next;
        div_cnt_reg        <= div_cnt_next;
        res_read_reg       <= res_read_next;
        res_prg_hit_reg    <= res_prg_hit_next;
        res_prg_addr_reg   <= res_prg_addr_next;
        res_chr_hit_reg    <= res_chr_hit_next;
        res_chr_addr_reg   <= res_chr_addr_next;
        res_ciram_hit_reg  <= res_ciram_hit_next;
        res_ciram_addr_reg <= res_ciram_addr_next;
        res_irq_reg        <= res_irq_next;
        if (cmd.load_out)
        begin
            out_read_reg       <= res_read_reg;
            out_prg_hit_reg    <= res_prg_hit_reg;
            out_prg_addr_reg   <= res_prg_addr_reg;
            out_chr_hit_reg    <= res_chr_hit_reg;
            out_chr_addr_reg   <= res_chr_addr_reg;
            out_ciram_hit_reg  <= res_ciram_hit_reg;
            out_ciram_addr_reg <= res_ciram_addr_reg;
            out_irq_reg        <= res_irq_reg;
        end
    end

    assign read_data       = out_read_reg;
    assign prg_hit         = out_prg_hit_reg;
    assign prg_rom_address = out_prg_addr_reg;
    assign chr_hit         = out_chr_hit_reg;
    assign chr_rom_address = out_chr_addr_reg;
    assign ciram_hit       = out_ciram_hit_reg;
    assign ciram_address   = out_ciram_addr_reg;
    assign irq_pulse       = out_irq_reg;

endmodule

@@ tb/sv/mapper_monitor.sv @@
module mapper_monitor
(
    input  logic   clk,
    input  logic   rst_n,
    cbm_item_if    item,
    cbm_result_if  result,
    cbm_cfg_if     cfg,
    output int     mismatches,
    output int     outstanding,
    output int     results_checked,
    output int     irq_pulses
);
    timeunit 1ns;
    timeprecision 1ps;

    import cbm_pkg::*;

    typedef struct packed
    {
        logic [7:0]  read_data;
        logic        prg_hit;
        logic [18:0] prg_rom_address;
        logic        chr_hit;
        logic [17:0] chr_rom_address;
        logic        ciram_hit;
        logic [10:0] ciram_address;
        logic        irq_pulse;
    } mapper_outputs_t;

    // Shadow copy of the mapper registers and of the two bank counts
    logic [15:0] scan_count;
    logic        scan_irq_on;
    logic [7:0]  pattern_page [8];
    logic [7:0]  nt_select [4];
    logic [5:0]  prg_slot [3];
    logic [6:0]  prg_banks;
    logic [8:0]  chr_pages;

    mapper_outputs_t pending_outputs [$];
    int err_count = 0;
    int checked   = 0;
    int pulses    = 0;

    assign mismatches      = err_count;
    assign results_checked = checked;
    assign irq_pulses      = pulses;

    // Apply one access to the shadow registers and return what the block must answer
    function automatic mapper_outputs_t mapped_outputs(cmd_code_t c, logic [15:0] a,
                                                       logic [7:0] d);
        mapper_outputs_t o;
        logic [4:0]  sel;
        logic [13:0] ppu;
        logic [7:0]  nt;
        logic [8:0]  page;
        logic [6:0]  last_bank;
        logic [5:0]  bank;
        o = '0;
        o.read_data = READ_IDLE;
        sel = a[15:11];
        ppu = a[13:0];
        case (c)
            CMD_WRITE:
            begin
                if (sel == SEL_IRQ_LO)
                    scan_count = {1'b0, scan_count[14:8], d};
                else if (sel == SEL_IRQ_HI)
                begin
                    scan_count  = {1'b0, d[6:0], scan_count[7:0]};
                    scan_irq_on = d[7];
                end
                else if (sel >= SEL_CHR_FIRST && sel <= SEL_CHR_LAST)
                    pattern_page[sel[2:0]] = d;
                else if (sel >= SEL_NT_FIRST && sel <= SEL_NT_LAST)
                    nt_select[sel[1:0]] = d;
                else if (sel >= SEL_PRG_FIRST && sel <= SEL_PRG_LAST)
                    prg_slot[sel - SEL_PRG_FIRST] = d[5:0];
            end
            CMD_READ:
            begin
                if (sel == SEL_IRQ_LO)
                    o.read_data = scan_count[7:0];
                else if (sel == SEL_IRQ_HI)
                    o.read_data = scan_count[15:8] | {scan_irq_on, 7'b0};
                else if (a[15])
                begin
                    if (a[14:13] == PRG_FIXED)
                    begin
                        last_bank = prg_banks - 7'd1;
                        bank = last_bank[5:0];
                    end
                    else
                        bank = prg_slot[a[14:13]];
                    o.prg_hit = 1'b1;
                    o.prg_rom_address = {bank, a[12:0]};
                end
            end
            CMD_PPU:
            begin
                if (!ppu[13])
                begin
                    o.chr_hit = 1'b1;
                    o.chr_rom_address = {pattern_page[ppu[12:10]], ppu[9:0]};
                end
                else
                begin
                    nt = nt_select[ppu[11:10]];
                    if (nt < NT_CIRAM)
                    begin
                        // a page count of zero leaves the select unreduced
                        page = (chr_pages == 9'd0) ? {1'b0, nt} : {1'b0, nt} % chr_pages;
                        o.chr_hit = 1'b1;
                        o.chr_rom_address = {page[7:0], ppu[9:0]};
                    end
                    else
                    begin
                        o.ciram_hit = 1'b1;
                        o.ciram_address = {nt[0], ppu[9:0]};
                    end
                end
            end
            default:
            begin
                if (scan_irq_on)
                begin
                    scan_count = scan_count + IRQ_STEP;
                    if (scan_count >= IRQ_LIMIT)
                    begin
                        o.irq_pulse = 1'b1;
                        scan_count = scan_count | IRQ_FLAG;
                    end
                end
            end
        endcase
        return o;
    endfunction

    task automatic compare_field(string field, logic [31:0] got, logic [31:0] want);
        if (got !== want)
        begin
            err_count++;
            if (err_count <= 10)
                $display("result %0d: %s expected 0x%0h, got 0x%0h at %0t",
                         checked, field, want, got, $time);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        mapper_outputs_t want;
        if (!rst_n)
        begin
            scan_count  = '0;
            scan_irq_on = 1'b0;
            for (int i = 0; i < 8; i++)
                pattern_page[i] = 8'(i);
            for (int i = 0; i < 4; i++)
                nt_select[i] = NT_CIRAM;
            for (int i = 0; i < 3; i++)
                prg_slot[i] = 6'(i);
            prg_banks = 7'd64;
            chr_pages = 9'd256;
            pending_outputs.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == CFG_PRG_COUNT)
                    prg_banks = cfg.data[6:0];
                else
                    chr_pages = cfg.data;
            end
            // retire the oldest expectation before queueing this edge's item
            if (result.valid && result.ready)
            begin
                if (pending_outputs.size() == 0)
                begin
                    err_count++;
                    if (err_count <= 10)
                        $display("result beat with nothing expected at %0t", $time);
                end
                else
                begin
                    want = pending_outputs.pop_front();
                    compare_field("read_data", 32'(result.read_data), 32'(want.read_data));
                    compare_field("prg_hit", 32'(result.prg_hit), 32'(want.prg_hit));
                    compare_field("prg_rom_address", 32'(result.prg_rom_address),
                                  32'(want.prg_rom_address));
                    compare_field("chr_hit", 32'(result.chr_hit), 32'(want.chr_hit));
                    compare_field("chr_rom_address", 32'(result.chr_rom_address),
                                  32'(want.chr_rom_address));
                    compare_field("ciram_hit", 32'(result.ciram_hit), 32'(want.ciram_hit));
                    compare_field("ciram_address", 32'(result.ciram_address),
                                  32'(want.ciram_address));
                    compare_field("irq_pulse", 32'(result.irq_pulse), 32'(want.irq_pulse));
                    checked++;
                    if (want.irq_pulse)
                        pulses++;
                end
            end
            if (item.valid && item.ready)
                pending_outputs.push_back(mapped_outputs(cmd_code_t'(item.cmd),
                                                         item.address, item.data));
            outstanding <= pending_outputs.size();
        end
    end

endmodule

@@ tb/sv/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cbm_pkg::*;

    logic clk;
    logic rst_n;

    // Idle and stall odds, in percent, for the sender and the receiver
    int send_gap_pct   = 0;
    int recv_stall_pct = 0;

    int mismatches;
    int outstanding;
    int results_checked;
    int irq_pulses;
    int sent_by_cmd [4] = '{0, 0, 0, 0};

    cbm_item_if   item_bus ();
    cbm_result_if result_bus ();
    cbm_cfg_if    cfg_bus ();

    cartridge_bank_mapper_with_irq dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_bus),
        .result (result_bus),
        .cfg    (cfg_bus)
    );

    mapper_monitor monitor
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .item            (item_bus),
        .result          (result_bus),
        .cfg             (cfg_bus),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .results_checked (results_checked),
        .irq_pulses      (irq_pulses)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #10 clk = ~clk;
    end

    // Receiver: redraw ready on every edge from the current stall odds
    always @(posedge clk)
        result_bus.ready <= ($urandom_range(99) >= recv_stall_pct);

    // Hard stop: far beyond the slowest legal run of this stimulus
    initial
    begin
        #(10_000_000);
        $display("cartridge_bank_mapper_with_irq test failed");
        $finish;
    end

    // Present one access and hold it until the block takes the beat. Ready is looked
    // at on the falling edge, where every signal has settled; return on the accepting
    // rising edge so the caller can drive the next beat straight away.
    task automatic send_access(cmd_code_t c, logic [15:0] a, logic [7:0] d);
        while ($urandom_range(99) < send_gap_pct)
        begin
            item_bus.valid <= 1'b0;
            @(posedge clk);
        end
        item_bus.valid   <= 1'b1;
        item_bus.cmd     <= c;
        item_bus.address <= a;
        item_bus.data    <= d;
        @(negedge clk);
        while (!item_bus.ready)
            @(negedge clk);
        @(posedge clk);
        sent_by_cmd[c]++;
    endtask

    // Drop valid and wait until every result owed has been taken
    task automatic wait_drained();
        item_bus.valid <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0);
    endtask

    // Write one bank-count register while the block is idle
    task automatic write_reg(logic idx, logic [CFG_DATA_W-1:0] value);
        wait_drained();
        // let the slowest access (a reduced nametable fetch) clear the pipe
        repeat (10) @(posedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        @(negedge clk);
        while (!cfg_bus.ready)
            @(negedge clk);
        @(posedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    // Draw one access. Writes mostly hit real registers, counter-high writes mostly
    // arm the IRQ, often near its limit so ticks reach the pulse, and reads favour
    // the counter and program space.
    task automatic send_random_access();
        int unsigned pick;
        int unsigned roll;
        logic [15:0] a;
        logic [7:0]  d;
        cmd_code_t   c;
        pick = $urandom_range(99);
        roll = $urandom_range(99);
        a = 16'($urandom_range(16'hFFFF));
        d = 8'($urandom_range(8'hFF));
        if (pick < 25)
        begin
            c = CMD_WRITE;
            if (roll < 10)
                ;
            else if (roll < 16)
            begin
                a[15:11] = SEL_IRQ_HI;
                d[7] = ($urandom_range(3) != 0);
                if ($urandom_range(1))
                    d[6:3] = 4'hF;
            end
            else if (roll < 22)
                a[15:11] = SEL_IRQ_LO;
            else
                a[15:11] = 5'($urandom_range(SEL_PRG_LAST, SEL_CHR_FIRST));
        end
        else if (pick < 50)
        begin
            c = CMD_READ;
            if (roll < 40)
                a[15:11] = roll[0] ? SEL_IRQ_HI : SEL_IRQ_LO;
            else if (roll < 90)
                a[15] = 1'b1;
        end
        else if (pick < 85)
            c = CMD_PPU;
        else
            c = CMD_TICK;
        send_access(c, a, d);
    endtask

    initial
    begin : stimulus
        logic [CFG_DATA_W-1:0] prg_value;
        logic [CFG_DATA_W-1:0] chr_value;

        rst_n = 1'b0;
        item_bus.valid   = 1'b0;
        item_bus.cmd     = CMD_WRITE;
        item_bus.address = '0;
        item_bus.data    = '0;
        cfg_bus.valid    = 1'b0;
        cfg_bus.index    = CFG_PRG_COUNT;
        cfg_bus.data     = '0;
        result_bus.ready = 1'b0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, reset bank counts, no idling.
        // Counter bytes at reset, then dead CPU space on both sides of the counter.
        send_access(CMD_READ, 16'h5000, 8'h00);
        send_access(CMD_READ, 16'h5FFF, 8'h00);
        send_access(CMD_READ, 16'h4FFF, 8'h00);
        send_access(CMD_READ, 16'h7FFF, 8'h00);
        // tick while the IRQ is disabled: no change, no pulse
        send_access(CMD_TICK, 16'h0000, 8'h00);
        // pattern fetch at reset, and one with bits 15:14 set in the nametable mirror
        send_access(CMD_PPU, 16'h0000, 8'h00);
        send_access(CMD_PPU, 16'hFFFF, 8'h00);
        // first and last pattern bank registers, at the data extremes
        send_access(CMD_WRITE, 16'h8000, 8'hFF);
        send_access(CMD_WRITE, 16'hBFFF, 8'h00);
        // nametable selects: ROM page 0, the highest ROM select, RAM page 1
        send_access(CMD_WRITE, 16'hC000, 8'h00);
        send_access(CMD_WRITE, 16'hD000, 8'hDF);
        send_access(CMD_WRITE, 16'hC800, 8'hE1);
        // program banks (data above six bits gets masked), then the unused slot
        send_access(CMD_WRITE, 16'hE000, 8'hFF);
        send_access(CMD_WRITE, 16'hF000, 8'h15);
        send_access(CMD_WRITE, 16'hF800, 8'hAA);
        // program space in slot 0, slot 2 and the fixed last bank
        send_access(CMD_READ, 16'h8000, 8'h00);
        send_access(CMD_READ, 16'hDFFF, 8'h00);
        send_access(CMD_READ, 16'hFFFF, 8'h00);
        // pattern fetch through the rewritten bank, mirrored ROM nametable, RAM nametable
        send_access(CMD_PPU, 16'h0000, 8'h00);
        send_access(CMD_PPU, 16'h3BFF, 8'h00);
        send_access(CMD_PPU, 16'h27FF, 8'h00);
        // arm the counter so one tick lands exactly on the limit, then wrap past 0xFFFF
        send_access(CMD_WRITE, 16'h5FFF, 8'hFF);
        send_access(CMD_WRITE, 16'h5000, 8'h8D);
        send_access(CMD_TICK, 16'h0000, 8'h00);
        send_access(CMD_READ, 16'h5800, 8'h00);
        send_access(CMD_TICK, 16'h0000, 8'h00);
        send_access(CMD_READ, 16'h57FF, 8'h00);

        // Random part: six bank-count settings, extremes first. Hold each idling mode
        // for two settings: slow receiver, then slow sender, then full rate.
        for (int seg = 0; seg < 6; seg++)
        begin
            case (seg)
                0:       begin prg_value = 9'd64;  chr_value = 9'd256; end
                1:       begin prg_value = 9'd1;   chr_value = 9'd8;   end
                2:       begin prg_value = 9'd0;   chr_value = 9'd0;   end
                3:       begin prg_value = 9'd127; chr_value = 9'd511; end
                default:
                begin
                    prg_value = 9'($urandom_range(64, 1));
                    chr_value = 9'($urandom_range(256, 8));
                end
            endcase
            write_reg(CFG_PRG_COUNT, prg_value);
            write_reg(CFG_CHR_COUNT, chr_value);
            case (seg / 2)
                0:       begin send_gap_pct = 7;  recv_stall_pct = 87; end
                1:       begin send_gap_pct = 87; recv_stall_pct = 7;  end
                default: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
            endcase
            repeat (305)
                send_random_access();
        end

        // Drain, then give the block a few more cycles to show any stray beat
        wait_drained();
        repeat (20) @(posedge clk);

        $display("Ran %0d CPU writes, %0d CPU reads, %0d PPU fetches and %0d scanline ticks",
                 sent_by_cmd[CMD_WRITE], sent_by_cmd[CMD_READ], sent_by_cmd[CMD_PPU],
                 sent_by_cmd[CMD_TICK]);
        $display("over six bank-count settings; %0d results compared, %0d with an IRQ pulse",
                 results_checked, irq_pulses);
        if (mismatches == 0)
            $display("cartridge_bank_mapper_with_irq test passed");
        else
            $display("cartridge_bank_mapper_with_irq test failed");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+sv
sv/cbm_pkg.sv
sv/cbm_if.sv
sv/cbm_ctrl.sv
sv/cbm_datapath.sv
sv/cartridge_bank_mapper_with_irq.sv
tb/sv/mapper_monitor.sv
tb/sv/tb.sv
